// ----- rtl/core/lkt_pkg.sv -----
// Shared types, opcodes and limits of the link key table.
`default_nettype none

package lkt_pkg;

	// table limits
	localparam int LKT_DEPTH_DEFAULT = 16;
	localparam int LKT_DEPTH_MAX     = 64;
	localparam int LKT_IDX_W         = $clog2(LKT_DEPTH_MAX);
	localparam int LKT_CNT_W         = 5;

	localparam logic [LKT_CNT_W-1:0] LKT_MAX_KEYS_RESET = 5'd16;

	// request opcodes
	localparam logic [2:0] OP_WRITE      = 3'd0;
	localparam logic [2:0] OP_READ       = 3'd1;
	localparam logic [2:0] OP_GET        = 3'd2;
	localparam logic [2:0] OP_DELETE     = 3'd3;
	localparam logic [2:0] OP_DELETE_ALL = 3'd4;
	localparam logic [2:0] OP_COUNT      = 3'd5;

	typedef logic [47:0]  addr_t;
	typedef logic [127:0] key_t;

	// request word
	typedef struct packed {
		logic [2:0]  opcode;
		logic [47:0] device_address;
		logic [63:0] key_upper;
		logic [63:0] key_lower;
	} req_word_t;

	// response word
	typedef struct packed {
		logic [LKT_CNT_W-1:0] result_count;
		logic                 found;
		logic [63:0]          out_key_upper;
		logic [63:0]          out_key_lower;
	} rsp_word_t;

	// lookup status from the address table
	typedef struct packed {
		logic                 hit;
		logic [LKT_IDX_W-1:0] hit_idx;
		logic                 free_ok;
		logic [LKT_IDX_W-1:0] free_idx;
		logic [LKT_CNT_W-1:0] count;
	} lkt_status_t;

	// update command to the address table
	typedef struct packed {
		logic                 insert;
		logic                 clear_one;
		logic                 clear_all;
		logic [LKT_IDX_W-1:0] idx;
		addr_t                addr;
	} lkt_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/lkt_cam.sv -----
// Address table: valid bits, stored addresses, parallel match and entry count.
`default_nettype none

module lkt_cam #(
	parameter int TABLE_DEPTH = lkt_pkg::LKT_DEPTH_DEFAULT
) (
	input  wire               clk,
	input  wire               arst_n,
	input  lkt_pkg::addr_t    lookup_addr,
	input  lkt_pkg::lkt_cmd_t cmd,
	output lkt_pkg::lkt_status_t status
);
	import lkt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [TABLE_DEPTH-1:0] valid_q;
	addr_t                  entry_address_q [TABLE_DEPTH];
	logic [LKT_CNT_W-1:0]   count_q;

	logic [TABLE_DEPTH-1:0] match;
	logic [TABLE_DEPTH-1:0] free_oh;
	logic [LKT_IDX_W-1:0]   hit_idx;
	logic [LKT_IDX_W-1:0]   free_idx;

	// compare every entry and pick the lowest free slot
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		free_oh  = ~valid_q & (valid_q + TABLE_DEPTH'(1));
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = valid_q[i] && (entry_address_q[i] == lookup_addr);
			if (match[i]) begin
				hit_idx = hit_idx | LKT_IDX_W'(i);
			end
			if (free_oh[i]) begin
				free_idx = free_idx | LKT_IDX_W'(i);
			end
		end
	end

	assign status.hit      = |match;
	assign status.hit_idx  = hit_idx;
	assign status.free_ok  = |(~valid_q);
	assign status.free_idx = free_idx;
	assign status.count    = count_q;

	// update valid bits and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.clear_all) begin
				valid_q <= '0;
				count_q <= '0;
			end else if (cmd.insert) begin
				valid_q[cmd.idx[IDX_W-1:0]] <= 1'b1;
				count_q <= count_q + LKT_CNT_W'(1);
			end else if (cmd.clear_one) begin
				valid_q[cmd.idx[IDX_W-1:0]] <= 1'b0;
				count_q <= count_q - LKT_CNT_W'(1);
			end
		end
	end

	// store the address of a new entry
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			entry_address_q[cmd.idx[IDX_W-1:0]] <= cmd.addr;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lkt_key_ram.sv -----
// Key store: one write port and one registered read port.
`default_nettype none

module lkt_key_ram #(
	parameter int TABLE_DEPTH = lkt_pkg::LKT_DEPTH_DEFAULT
) (
	input  wire                              clk,
	input  wire                              we,
	input  wire  [lkt_pkg::LKT_IDX_W-1:0]    waddr,
	input  lkt_pkg::key_t                    wdata,
	input  wire                              re,
	input  wire  [lkt_pkg::LKT_IDX_W-1:0]    raddr,
	output lkt_pkg::key_t                    rdata
);
	import lkt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	key_t mem [TABLE_DEPTH];
	key_t rdata_q;

	// write the key
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[IDX_W-1:0]] <= wdata;
		end
	end

	// register the read, hold while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr[IDX_W-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/link_key_table_core.sv -----
// Top level of the link key table: request register, lookup, update and response register.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req  (req_word_t)
//  rsp     | out       | rsp_valid / rsp_stall | rsp  (rsp_word_t)
//  cfg     | in        | cfg_wr_en             | cfg_wr_data (max_keys)
//
// One request word a cycle while req_stall is low; each word goes from the request register to the response register.
// The table lookup and update sit between the request register and the
// response register; keys come from a memory with a registered read port.
// Reset clears all valid bits and the count at once and loads max_keys with 16.
// A stalled response holds the pipe; req_stall rises only when both stages are full.
`default_nettype none

module link_key_table_core #(
	parameter int TABLE_DEPTH = lkt_pkg::LKT_DEPTH_DEFAULT
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               req_valid,
	output logic                              req_stall,
	input  lkt_pkg::req_word_t                req,
	output logic                              rsp_valid,
	input  wire                               rsp_stall,
	output lkt_pkg::rsp_word_t                rsp,
	input  wire                               cfg_wr_en,
	input  wire  [lkt_pkg::LKT_CNT_W-1:0]     cfg_wr_data
);
	import lkt_pkg::*;

	logic                 valid_s1;
	req_word_t            req_s1;
	logic                 valid_s2;
	logic [LKT_CNT_W-1:0] result_count_s2;
	logic                 found_s2;
	logic [LKT_CNT_W-1:0] max_keys_q;

	logic                 advance;
	logic                 load_s1;
	lkt_status_t          status;
	lkt_cmd_t             cmd;
	logic                 ram_we;
	logic [LKT_IDX_W-1:0] ram_waddr;
	key_t                 ram_rdata;
	logic [LKT_CNT_W-1:0] result_count;
	logic                 found;

	// handshake
	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign load_s1   = !valid_s1 || advance;
	assign req_stall = !load_s1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_keys_q <= LKT_MAX_KEYS_RESET;
		end else if (cfg_wr_en) begin
			max_keys_q <= cfg_wr_data;
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req_valid) begin
			req_s1 <= req;
		end
	end

	lkt_cam #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_cam (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_addr(req_s1.device_address),
		.cmd        (cmd),
		.status     (status)
	);

	// decode the request against the lookup; act only when the word advances
	always_comb begin
		cmd          = '0;
		cmd.addr     = req_s1.device_address;
		ram_we       = 1'b0;
		ram_waddr    = status.hit_idx;
		result_count = '0;
		found        = 1'b0;
		unique case (req_s1.opcode)
			OP_WRITE: begin
				if (status.count >= max_keys_q) begin
					result_count = '0;
				end else if (status.hit) begin
					ram_we       = advance;
					result_count = LKT_CNT_W'(1);
				end else if (status.free_ok) begin
					cmd.insert   = advance;
					cmd.idx      = status.free_idx;
					ram_we       = advance;
					ram_waddr    = status.free_idx;
					result_count = LKT_CNT_W'(1);
				end
			end
			OP_READ: begin
				result_count = LKT_CNT_W'(status.hit);
			end
			OP_GET: begin
				result_count = LKT_CNT_W'(status.hit);
				found        = status.hit;
			end
			OP_DELETE: begin
				cmd.clear_one = advance && status.hit;
				cmd.idx       = status.hit_idx;
				result_count  = LKT_CNT_W'(status.hit);
			end
			OP_DELETE_ALL: begin
				cmd.clear_all = advance;
				result_count  = status.count;
			end
			OP_COUNT: begin
				result_count = status.count;
			end
			default: begin
				result_count = '0;
			end
		endcase
	end

	lkt_key_ram #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({req_s1.key_upper, req_s1.key_lower}),
		.re   (advance),
		.raddr(status.hit_idx),
		.rdata(ram_rdata)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_count_s2 <= result_count;
			found_s2        <= found;
		end
	end

	// drive the response word; the key shows only on a found get
	assign rsp_valid         = valid_s2;
	assign rsp.result_count  = result_count_s2;
	assign rsp.found         = found_s2;
	assign rsp.out_key_upper = found_s2 ? ram_rdata[127:64] : 64'd0;
	assign rsp.out_key_lower = found_s2 ? ram_rdata[63:0]   : 64'd0;

endmodule

`default_nettype wire

// ----- rtl/core/lkt_checker.sv -----
// Port checker for the link key table and its bind to the top level.
`default_nettype none

module lkt_checker #(
	parameter int TABLE_DEPTH = lkt_pkg::LKT_DEPTH_DEFAULT
) (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           req_stall,
	input wire                           rsp_valid,
	input wire                           rsp_stall,
	input lkt_pkg::rsp_word_t            rsp
);
	import lkt_pkg::*;

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response word changed");

	// a found key reports one hit
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.result_count == LKT_CNT_W'(1))
		else $error("found set without result one");

	// no key leaks unless found
	a_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.out_key_upper == 64'd0 &&
			rsp.out_key_lower == 64'd0)
		else $error("key driven without found");

	// counts never exceed the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> int'(rsp.result_count) <= TABLE_DEPTH)
		else $error("result count above table depth");

	// requests stall only behind a stalled response word
	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a stalled response");

endmodule

bind link_key_table_core lkt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_lkt_checker (.*);

`default_nettype wire
